// ===== rtl/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;
	localparam int ArenaBytes = 4096;
	localparam int HeaderBytes = 8;
	localparam int OffW = $clog2(ArenaBytes);
	localparam int ReqW = OffW + 1;
	localparam int HdrW = 2 * OffW + 1;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_ZERO = 3'd1;
	localparam logic [2:0] ST_NOFIT = 3'd2;
	localparam logic [2:0] ST_NULL = 3'd3;
	localparam logic [2:0] ST_NOTALLOC = 3'd4;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE = 1'b1;

	typedef struct packed {
		logic taken;
		logic [OffW-1:0] size;
		logic [OffW-1:0] prev;
	} hdr_t;
endpackage
`default_nettype wire

// ===== rtl/ffha_ram.sv =====
`default_nettype none
module ffha_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
// channel | signals                  | handshake            | fields
// in      | request side             | valid / ready        | kind, request_size, payload_offset
// out     | result side              | out_valid / out_ready| status, result_offset
// a zero-size allocate or a null free is answered at the accepting edge
// otherwise the first header is checked in the cycle after the transfer, and every
// further header visited in the chain walk takes a read state and a check state
// a split allocate adds the S_SPLIT write, plus a link read and write when a block follows the new free block;
// a found free adds neighbor reads, merges and back links
// after reset the S_INIT state writes the single free block before ready rises
// a waiting result holds ready low unless out_ready is high in the same cycle
`default_nettype none
module first_fit_heap_allocator
	import ffha_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic valid,
	output logic ready,
	input wire logic kind,
	input wire logic [12:0] request_size,
	input wire logic [11:0] payload_offset,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] status,
	output logic [11:0] result_offset
);
	typedef enum logic [10:0] {
		S_INIT = 11'b00000000001,
		S_IDLE = 11'b00000000010,
		S_RD = 11'b00000000100,
		S_CHK = 11'b00000001000,
		S_SPLIT = 11'b00000010000,
		S_NXRD = 11'b00000100000,
		S_NX = 11'b00001000000,
		S_PVRD = 11'b00010000000,
		S_PV = 11'b00100000000,
		S_LKRD = 11'b01000000000,
		S_LK = 11'b10000000000
	} state_t;

	state_t st_q;
	logic kind_q;
	logic [ReqW-1:0] want_q;
	logic [OffW-1:0] ptr_q, addr_q, cur_q, cur_size_q, cur_prev_q, link_val_q;
	logic lk_last_q;
	logic res_pend_q;
	logic [2:0] res_st_q;
	logic [OffW-1:0] res_off_q;
	logic done;
	logic [2:0] done_st;
	logic [OffW-1:0] done_off;

	logic we;
	logic [OffW-1:0] waddr, raddr;
	hdr_t wdata, rdata;

	logic [ReqW:0] after_c, want_hdr_c, split_size_c, merge_size_c, cur_after_c;
	logic fit_c, split_c, hit_c, end_c, cur_end_c;

	ffha_ram #(.Width(HdrW), .Depth(ArenaBytes)) u_hdr (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// end offset of the block just read
	assign after_c = (ReqW+1)'(addr_q) + (ReqW+1)'(HeaderBytes) + (ReqW+1)'(rdata.size);
	assign end_c = after_c >= (ReqW+1)'(ArenaBytes);
	assign want_hdr_c = (ReqW+1)'(want_q) + (ReqW+1)'(HeaderBytes);
	assign fit_c = !rdata.taken && (want_q <= ReqW'(rdata.size));
	// leftover must hold a header and at least one byte
	assign split_c = want_hdr_c < (ReqW+1)'(rdata.size);
	assign split_size_c = (ReqW+1)'(rdata.size) - want_hdr_c;
	assign hit_c = rdata.taken
		&& ((ReqW+1)'(addr_q) + (ReqW+1)'(HeaderBytes) == (ReqW+1)'(ptr_q));
	assign merge_size_c = (ReqW+1)'(cur_size_q) + (ReqW+1)'(HeaderBytes)
		+ (ReqW+1)'(rdata.size);
	assign cur_after_c = (ReqW+1)'(cur_q) + (ReqW+1)'(HeaderBytes) + (ReqW+1)'(cur_size_q);
	assign cur_end_c = cur_after_c >= (ReqW+1)'(ArenaBytes);

	assign ready = (st_q == S_IDLE) && !(res_pend_q && !out_ready);
	assign out_valid = res_pend_q;
	assign status = res_st_q;
	assign result_offset = res_off_q;

	always_comb begin
		we = 1'b0;
		waddr = addr_q;
		wdata = rdata;
		raddr = addr_q;
		done = 1'b0;
		done_st = ST_OK;
		done_off = '0;
		case (st_q)
			S_INIT: begin
				we = 1'b1;
				waddr = '0;
				wdata = '{taken: 1'b0, size: OffW'(ArenaBytes - HeaderBytes), prev: '0};
			end
			S_IDLE: begin
				raddr = '0;
				if (valid && ready) begin
					if (kind == KIND_ALLOC && request_size == '0) begin
						done = 1'b1;
						done_st = ST_ZERO;
					end else if (kind == KIND_FREE && payload_offset == '0) begin
						done = 1'b1;
						done_st = ST_NULL;
					end
				end
			end
			S_CHK: begin
				if (kind_q == KIND_ALLOC) begin
					if (fit_c) begin
						we = 1'b1;
						wdata.taken = 1'b1;
						if (split_c) begin
							wdata.size = want_q[OffW-1:0];
						end else begin
							done = 1'b1;
							done_off = addr_q + OffW'(HeaderBytes);
						end
					end else if (end_c) begin
						done = 1'b1;
						done_st = ST_NOFIT;
					end
				end else begin
					if (hit_c) begin
						we = 1'b1;
						wdata.taken = 1'b0;
						if (end_c && addr_q == '0) done = 1'b1;
					end else if (end_c) begin
						done = 1'b1;
						done_st = ST_NOTALLOC;
					end
				end
			end
			S_SPLIT: begin
				// new free block after the granted one
				we = 1'b1;
				waddr = cur_q;
				wdata = '{taken: 1'b0, size: cur_size_q, prev: ptr_q};
				if (cur_end_c) begin
					done = 1'b1;
					done_off = ptr_q + OffW'(HeaderBytes);
				end
			end
			S_NX: begin
				if (!rdata.taken) begin
					we = 1'b1;
					waddr = cur_q;
					wdata = '{taken: 1'b0, size: merge_size_c[OffW-1:0], prev: cur_prev_q};
					if (end_c && cur_q == '0) done = 1'b1;
				end else if (cur_q == '0) begin
					done = 1'b1;
				end
			end
			S_PV: begin
				if (!rdata.taken) begin
					we = 1'b1;
					wdata.size = merge_size_c[OffW-1:0];
					if (cur_end_c) done = 1'b1;
				end else begin
					done = 1'b1;
				end
			end
			S_LK: begin
				we = 1'b1;
				wdata.prev = link_val_q;
				if (lk_last_q) begin
					done = 1'b1;
					if (kind_q == KIND_ALLOC) done_off = ptr_q + OffW'(HeaderBytes);
				end else if (cur_q == '0) begin
					done = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_INIT;
			res_pend_q <= 1'b0;
			res_st_q <= ST_OK;
			res_off_q <= '0;
			kind_q <= KIND_ALLOC;
			want_q <= '0;
			ptr_q <= '0;
			addr_q <= '0;
			cur_q <= '0;
			cur_size_q <= '0;
			cur_prev_q <= '0;
			link_val_q <= '0;
			lk_last_q <= 1'b0;
		end else begin
			res_pend_q <= done || (res_pend_q && !out_ready);
			if (done) begin
				res_st_q <= done_st;
				res_off_q <= done_off;
			end
			case (st_q)
				S_INIT: st_q <= S_IDLE;
				S_IDLE: begin
					if (valid && ready) begin
						kind_q <= kind;
						want_q <= request_size;
						ptr_q <= payload_offset;
						addr_q <= '0;
						if (!done) st_q <= S_CHK;
					end
				end
				S_RD: st_q <= S_CHK;
				S_CHK: begin
					if (kind_q == KIND_ALLOC && fit_c && split_c) begin
						ptr_q <= addr_q;
						cur_q <= addr_q + OffW'(HeaderBytes) + want_q[OffW-1:0];
						cur_size_q <= split_size_c[OffW-1:0];
						st_q <= S_SPLIT;
					end else if (kind_q == KIND_FREE && hit_c) begin
						cur_q <= addr_q;
						cur_size_q <= rdata.size;
						cur_prev_q <= rdata.prev;
						if (!end_c) begin
							addr_q <= after_c[OffW-1:0];
							st_q <= S_NXRD;
						end else if (addr_q == '0) begin
							st_q <= S_IDLE;
						end else begin
							addr_q <= rdata.prev;
							st_q <= S_PVRD;
						end
					end else if (done) begin
						st_q <= S_IDLE;
					end else begin
						addr_q <= after_c[OffW-1:0];
						st_q <= S_RD;
					end
				end
				S_SPLIT: begin
					if (cur_end_c) begin
						st_q <= S_IDLE;
					end else begin
						link_val_q <= cur_q;
						lk_last_q <= 1'b1;
						addr_q <= cur_after_c[OffW-1:0];
						st_q <= S_LKRD;
					end
				end
				S_NXRD: st_q <= S_NX;
				S_NX: begin
					if (!rdata.taken) cur_size_q <= merge_size_c[OffW-1:0];
					if (!rdata.taken && !end_c) begin
						link_val_q <= cur_q;
						lk_last_q <= 1'b0;
						addr_q <= after_c[OffW-1:0];
						st_q <= S_LKRD;
					end else if (cur_q == '0) begin
						st_q <= S_IDLE;
					end else begin
						addr_q <= cur_prev_q;
						st_q <= S_PVRD;
					end
				end
				S_PVRD: st_q <= S_PV;
				S_PV: begin
					if (!rdata.taken && !cur_end_c) begin
						link_val_q <= addr_q;
						lk_last_q <= 1'b1;
						addr_q <= cur_after_c[OffW-1:0];
						st_q <= S_LKRD;
					end else begin
						st_q <= S_IDLE;
					end
				end
				S_LKRD: st_q <= S_LK;
				S_LK: begin
					if (lk_last_q || cur_q == '0) begin
						st_q <= S_IDLE;
					end else begin
						addr_q <= cur_prev_q;
						st_q <= S_PVRD;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q));
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(result_offset));
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_NOTALLOC);
	a_fail_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> result_offset == '0);
endmodule
`default_nettype wire
